// ===== hw/rtl/clcd_pkg.sv =====
// Shared types and constants for the two-row character display store.
// No dependencies; every other file in hw/rtl refers to this package by scope.
`default_nettype none

package clcd_pkg;

    // Display geometry: the 4-bit cell column field fixes the row length
    localparam int COLUMNS     = 16;
    localparam int ROWS        = 2;
    localparam int CELLS       = ROWS * COLUMNS;
    localparam int IDX_W       = $clog2(CELLS);
    localparam int COL_W       = 4;
    localparam int CUR_COL_W   = 5;
    localparam int CHAR_W      = 8;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [CHAR_W-1:0]    PRINT_LO = 8'd32;
    localparam logic [CHAR_W-1:0]    PRINT_HI = 8'd126;
    localparam logic [CHAR_W-1:0]    SPACE    = 8'h20;
    localparam logic [CUR_COL_W-1:0] LAST_COL = CUR_COL_W'(COLUMNS - 1);
    localparam logic [CUR_COL_W-1:0] END_COL  = CUR_COL_W'(COLUMNS);
    localparam logic [IDX_W-1:0]     LAST_IDX = IDX_W'(CELLS - 1);

    typedef enum logic [2:0] {
        OP_WRITE     = 3'd0,
        OP_CLEAR     = 3'd1,
        OP_CLEAR_EOL = 3'd2,
        OP_UP        = 3'd3,
        OP_DOWN      = 3'd4,
        OP_RIGHT     = 3'd5,
        OP_LEFT      = 3'd6,
        OP_SET_POS   = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_STREAM,
        BK_STATUS
    } back_state_t;

    // Input beat as it arrives on the port
    typedef struct packed {
        logic [2:0]           mode;
        logic [CHAR_W-1:0]    char_code;
        logic [1:0]           target_row;
        logic [4:0]           target_column;
    } cmd_in_t;

    // Classified command held in the queue
    typedef struct packed {
        op_t                  op;
        logic [CHAR_W-1:0]    char_code;
        logic                 printable;
        logic                 pos_ok;
        logic                 target_row;
        logic [CUR_COL_W-1:0] target_column;
    } cmd_t;

    // Result beat
    typedef struct packed {
        logic                 ok;
        logic                 cursor_row;
        logic [CUR_COL_W-1:0] cursor_column;
        logic                 has_cell;
        logic                 cell_row;
        logic [COL_W-1:0]     cell_column;
        logic [CHAR_W-1:0]    cell_char;
        logic                 last;
    } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/clcd_front.sv =====
// Front end: takes input beats, classifies them and holds them in a short queue.
// Depends on clcd_pkg.
`default_nettype none

module clcd_front (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              s_valid,
    output logic             s_ready,
    input  clcd_pkg::cmd_in_t s_data,
    output logic             cmd_valid,
    input  wire              cmd_ready,
    output clcd_pkg::cmd_t   cmd
);

    clcd_pkg::cmd_t                   entry_reg [clcd_pkg::QUEUE_DEPTH];
    logic [clcd_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [clcd_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [clcd_pkg::QPTR_W:0]        count_reg, count_next;
    clcd_pkg::cmd_t                   cls;
    logic                             push, pop;

    // Classify: decode the mode and range-check character and position
    always_comb begin
        cls.op            = clcd_pkg::op_t'(s_data.mode);
        cls.char_code     = s_data.char_code;
        cls.printable     = (s_data.char_code >= clcd_pkg::PRINT_LO) &&
                            (s_data.char_code <= clcd_pkg::PRINT_HI);
        cls.pos_ok        = (s_data.target_row <= 2'd1) &&
                            (s_data.target_column <= clcd_pkg::END_COL);
        cls.target_row    = s_data.target_row[0];
        cls.target_column = s_data.target_column;
    end

    assign s_ready   = (count_reg != (clcd_pkg::QPTR_W+1)'(clcd_pkg::QUEUE_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = entry_reg[rd_ptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = cmd_valid && cmd_ready;

    // Queue pointers and fill count
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/clcd_back.sv =====
// Back end: executes queued commands on the cell store and cursor, then
// streams the frame or a status beat through an output register. Uses clcd_pkg.
`default_nettype none

module clcd_back (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              cmd_valid,
    output logic             cmd_ready,
    input  clcd_pkg::cmd_t   cmd,
    output logic             m_valid,
    input  wire              m_ready,
    output clcd_pkg::res_t   m_data
);

    clcd_pkg::back_state_t            state_reg, state_next;
    logic [clcd_pkg::IDX_W-1:0]       idx_reg, idx_next;
    logic                             row_reg, row_next;
    logic [clcd_pkg::CUR_COL_W-1:0]   col_reg, col_next;
    logic                             ok_reg, ok_next;
    logic [clcd_pkg::CHAR_W-1:0]      cells_reg [clcd_pkg::CELLS];
    logic                             m_valid_reg, m_valid_next;
    clcd_pkg::res_t                   m_data_reg, m_data_next;

    // Execution results for the command at the queue head
    logic                             ex_row, ex_ok, ex_stream;
    logic [clcd_pkg::CUR_COL_W-1:0]   ex_col;
    logic                             ex_clr_all, ex_wr;
    logic [clcd_pkg::CELLS-1:0]       ex_eol_mask;
    logic [clcd_pkg::IDX_W-1:0]       ex_wr_addr;
    logic                             pop, out_free;

    assign out_free  = !m_valid_reg || m_ready;
    assign pop       = (state_reg == clcd_pkg::BK_IDLE) && cmd_valid;
    assign cmd_ready = (state_reg == clcd_pkg::BK_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Command execution: new cursor, cell writes, success and frame decision
    always_comb begin
        ex_row      = row_reg;
        ex_col      = col_reg;
        ex_ok       = 1'b1;
        ex_stream   = 1'b1;
        ex_clr_all  = 1'b0;
        ex_wr       = 1'b0;
        ex_eol_mask = '0;
        ex_wr_addr  = clcd_pkg::IDX_W'(int'(row_reg) * clcd_pkg::COLUMNS
                                      + int'(col_reg));
        unique case (cmd.op)
            clcd_pkg::OP_WRITE: begin
                if (cmd.printable) begin
                    ex_wr = 1'b1;
                    if (col_reg < clcd_pkg::LAST_COL) begin
                        ex_col = col_reg + 1'b1;
                    end else begin
                        // row end: store in last column, wrap only from row 0
                        ex_wr_addr = clcd_pkg::IDX_W'(int'(row_reg) * clcd_pkg::COLUMNS
                                                     + clcd_pkg::COLUMNS - 1);
                        if (!row_reg) begin
                            ex_row = 1'b1;
                            ex_col = '0;
                        end
                    end
                end
            end
            clcd_pkg::OP_CLEAR: begin
                ex_clr_all = 1'b1;
                ex_row     = 1'b0;
                ex_col     = '0;
            end
            clcd_pkg::OP_CLEAR_EOL: begin
                for (int j = 0; j < clcd_pkg::COLUMNS; j++) begin
                    if (clcd_pkg::CUR_COL_W'(j) >= col_reg) begin
                        ex_eol_mask[int'(row_reg) * clcd_pkg::COLUMNS + j] = 1'b1;
                    end
                end
            end
            clcd_pkg::OP_UP: begin
                if (!row_reg) begin
                    ex_ok     = 1'b0;
                    ex_stream = 1'b0;
                end else begin
                    ex_row = 1'b0;
                end
            end
            clcd_pkg::OP_DOWN: begin
                if (row_reg) begin
                    ex_ok     = 1'b0;
                    ex_stream = 1'b0;
                end else begin
                    ex_row = 1'b1;
                end
            end
            clcd_pkg::OP_RIGHT: begin
                if (col_reg >= clcd_pkg::END_COL) begin
                    if (row_reg) begin
                        ex_ok     = 1'b0;
                        ex_stream = 1'b0;
                    end else begin
                        ex_row = 1'b1;
                        ex_col = '0;
                    end
                end else begin
                    ex_col = col_reg + 1'b1;
                end
            end
            clcd_pkg::OP_LEFT: begin
                if (col_reg == '0) begin
                    if (!row_reg) begin
                        ex_ok     = 1'b0;
                        ex_stream = 1'b0;
                    end else begin
                        ex_row = 1'b0;
                        ex_col = clcd_pkg::END_COL;
                    end
                end else begin
                    ex_col = col_reg - 1'b1;
                end
            end
            clcd_pkg::OP_SET_POS: begin
                ex_stream = 1'b0;
                ex_ok     = cmd.pos_ok;
                if (cmd.pos_ok) begin
                    ex_row = cmd.target_row;
                    ex_col = cmd.target_column;
                end
            end
            default: begin
                ex_ok = 1'b1;
            end
        endcase
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            clcd_pkg::BK_IDLE: begin
                if (cmd_valid) begin
                    state_next = ex_stream ? clcd_pkg::BK_STREAM : clcd_pkg::BK_STATUS;
                end
            end
            clcd_pkg::BK_STREAM: begin
                if (out_free && idx_reg == clcd_pkg::LAST_IDX) begin
                    state_next = clcd_pkg::BK_IDLE;
                end
            end
            clcd_pkg::BK_STATUS: begin
                if (out_free) begin
                    state_next = clcd_pkg::BK_IDLE;
                end
            end
            default: state_next = clcd_pkg::BK_IDLE;
        endcase
    end

    // Outputs: cursor update, frame index and output register load
    always_comb begin
        row_next     = row_reg;
        col_next     = col_reg;
        ok_next      = ok_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        unique case (state_reg)
            clcd_pkg::BK_IDLE: begin
                if (pop) begin
                    row_next = ex_row;
                    col_next = ex_col;
                    ok_next  = ex_ok;
                    idx_next = '0;
                end
            end
            clcd_pkg::BK_STREAM: begin
                if (out_free) begin
                    m_valid_next              = 1'b1;
                    m_data_next.ok            = 1'b1;
                    m_data_next.cursor_row    = row_reg;
                    m_data_next.cursor_column = col_reg;
                    m_data_next.has_cell      = 1'b1;
                    m_data_next.cell_row      = idx_reg[clcd_pkg::IDX_W-1];
                    m_data_next.cell_column   = idx_reg[clcd_pkg::COL_W-1:0];
                    m_data_next.cell_char     = cells_reg[idx_reg];
                    m_data_next.last          = (idx_reg == clcd_pkg::LAST_IDX);
                    idx_next                  = idx_reg + 1'b1;
                end
            end
            clcd_pkg::BK_STATUS: begin
                if (out_free) begin
                    m_valid_next              = 1'b1;
                    m_data_next.ok            = ok_reg;
                    m_data_next.cursor_row    = row_reg;
                    m_data_next.cursor_column = col_reg;
                    m_data_next.has_cell      = 1'b0;
                    m_data_next.cell_row      = 1'b0;
                    m_data_next.cell_column   = '0;
                    m_data_next.cell_char     = '0;
                    m_data_next.last          = 1'b1;
                end
            end
            default: begin
                m_valid_next = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= clcd_pkg::BK_IDLE;
            idx_reg     <= '0;
            row_reg     <= 1'b0;
            col_reg     <= '0;
            ok_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            ok_reg      <= ok_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    // Cell store: clears are per-cell and independent, one character write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < clcd_pkg::CELLS; j++) begin
                cells_reg[j] <= clcd_pkg::SPACE;
            end
        end else if (pop) begin
            for (int j = 0; j < clcd_pkg::CELLS; j++) begin
                if (ex_clr_all || ex_eol_mask[j]) begin
                    cells_reg[j] <= clcd_pkg::SPACE;
                end else if (ex_wr && ex_wr_addr == clcd_pkg::IDX_W'(j)) begin
                    cells_reg[j] <= cmd.char_code;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/char_lcd_text_buffer_cursor.sv =====
// A command is executed when the back end accepts it; the stream or status state then loads
// its first result beat into the output register. A frame command sends one cell beat per
// cycle for all 32 cells while the output is free; a status-only command sends one beat.
// The two-entry command queue lets new beats in while a frame is still streaming.
// Reset: synchronous, active low; all cells read as spaces, cursor at row 0 column 0.
// Top level: front end (classify and queue) feeding back end (execute and stream).
`default_nettype none

module char_lcd_text_buffer_cursor (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_valid,
    output logic              s_ready,
    input  clcd_pkg::cmd_in_t s_data,
    output logic              m_valid,
    input  wire               m_ready,
    output clcd_pkg::res_t    m_data
);

    logic           cmd_valid, cmd_ready;
    clcd_pkg::cmd_t cmd;

    clcd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    clcd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

`ifndef SYNTHESIS
    // A status beat always closes its command
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.has_cell |-> m_data.last)
        else $error("status beat without last");

    // Frame beats only follow a successful command
    a_cell_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.has_cell |-> m_data.ok)
        else $error("frame beat on refused command");

    // Cursor column never goes beyond the past-end position
    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.cursor_column <= clcd_pkg::END_COL)
        else $error("cursor column out of range");

    // Frame beats run back to back once the previous one is taken
    a_stream_next: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_data.has_cell && !m_data.last |=>
        m_valid && m_data.has_cell &&
        ({m_data.cell_row, m_data.cell_column} ==
         $past({m_data.cell_row, m_data.cell_column}) + 5'd1))
        else $error("frame stream broken");
`endif

endmodule

`default_nettype wire
